// ===== src/bspa_pkg.sv =====
// Shared types and constants of the banked slot placement allocator.
// No dependencies; every other file but bspa_ram imports this package.
`default_nettype none

package bspa_pkg;

  localparam int NUM_BANKS_DEF    = 256;
  localparam int NUM_REGIONS_DEF  = 256;
  localparam int SLOT_GRANULE_DEF = 16;

  localparam logic [15:0] HEADER_LO   = 16'h0100;
  localparam logic [15:0] HEADER_END  = 16'h0150;
  localparam logic [15:0] BANKED_BASE = 16'h4000;
  localparam logic [14:0] SLOT_MAX    = 15'h7FFF;

  localparam logic [15:0] SECTION_BASE_RST  = 16'h0150;
  localparam logic [7:0]  SECTION_BANK_RST  = 8'd0;
  localparam logic        RETAIN_ENABLE_RST = 1'b1;

  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_SECTION_BASE  = 2'd0,
    REG_SECTION_BANK  = 2'd1,
    REG_RETAIN_ENABLE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] section_base;
    logic [7:0]  section_bank;
    logic        retain_enable;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  bank;
    logic [15:0] addr;
    logic [14:0] slot;
  } tab_entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic round1;
    logic round2;
    logic select;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/banked_slot_placement_allocator.sv =====
// Top level of the banked slot placement allocator.
// Depends on bspa_pkg, bspa_regs, bspa_ctrl, bspa_dp (and bspa_ram below it).
//
// Usage:
//   Input: an item is taken at a rising edge with start high and busy low.
//   func 0 starts a bank (sets its high-water mark), func 1 places a region.
//   Output: one result per item, valid on the result ports while done is high
//   for one cycle. The receiver cannot stall; results are never held.
//   Sequence: done is registered from the COMMIT state, and the result beat is
//   taken at the edge that ends the done cycle. One item is in flight at a time;
//   busy drops in the cycle done is high, so the next item can be taken then.
//   The steps are the registered RAM read, two stages of reciprocal granule
//   rounding, slot selection, and the commit that writes the bank and table
//   entries.
//   Reset: a clearing pass over max(NUM_REGIONS, NUM_BANKS) addresses zeroes the
//   placement table, high-water and retained-end memories; busy is high
//   meanwhile. Configuration writes are taken at any time, but only while
//   the block is idle do they have defined effect.
//   Config: APB registers at 0x0 section_base, 0x4 section_bank,
//   0x8 retain_enable; pready is always high.
`default_nettype none

module banked_slot_placement_allocator import bspa_pkg::*; #(
  parameter int NUM_BANKS    = NUM_BANKS_DEF,
  parameter int NUM_REGIONS  = NUM_REGIONS_DEF,
  parameter int SLOT_GRANULE = SLOT_GRANULE_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              func,
  input  wire logic [7:0]        region_id,
  input  wire logic [7:0]        bank,
  input  wire logic [15:0]       original_addr,
  input  wire logic [14:0]       region_bytes,
  output logic                   done,
  output logic      [15:0]       placed_addr,
  output logic      [14:0]       slot_bytes,
  output logic      [21:0]       linear_offset,
  output logic                   reused,
  output logic signed [15:0]     addr_delta
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  bspa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bspa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .stat  (stat)
  );

  bspa_dp #(
    .NUM_BANKS    (NUM_BANKS),
    .NUM_REGIONS  (NUM_REGIONS),
    .SLOT_GRANULE (SLOT_GRANULE)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg           (cfg),
    .func          (func),
    .region_id     (region_id),
    .bank          (bank),
    .original_addr (original_addr),
    .region_bytes  (region_bytes),
    .placed_addr   (placed_addr),
    .slot_bytes    (slot_bytes),
    .linear_offset (linear_offset),
    .reused        (reused),
    .addr_delta    (addr_delta)
  );

endmodule

`default_nettype wire

// ===== src/bspa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bspa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/bspa_regs.sv =====
// APB-style configuration registers: section base, section bank, retention.
// Depends on bspa_pkg.
`default_nettype none

module bspa_regs import bspa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.section_base  <= SECTION_BASE_RST;
      cfg.section_bank  <= SECTION_BANK_RST;
      cfg.retain_enable <= RETAIN_ENABLE_RST;
    end else if (wr) begin
      unique case (idx)
        REG_SECTION_BASE:  cfg.section_base  <= pwdata[15:0];
        REG_SECTION_BANK:  cfg.section_bank  <= pwdata[7:0];
        REG_RETAIN_ENABLE: cfg.retain_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SECTION_BASE:  prdata = {16'd0, cfg.section_base};
      REG_SECTION_BANK:  prdata = {24'd0, cfg.section_bank};
      REG_RETAIN_ENABLE: prdata = {31'd0, cfg.retain_enable};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/bspa_ctrl.sv =====
// Sequencer of the allocator: clearing pass, then one item at a time
// through rounding, selection and commit. Depends on bspa_pkg.
`default_nettype none

module bspa_ctrl import bspa_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  output logic       busy,
  output logic       done,
  output cmd_t       cmd,
  input  wire stat_t stat
);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_ROUND1 = 6'b000100,
    ST_ROUND2 = 6'b001000,
    ST_SELECT = 6'b010000,
    ST_COMMIT = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (stat.clear_last) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_ROUND1;
      ST_ROUND1: state_next = ST_ROUND2;
      ST_ROUND2: state_next = ST_SELECT;
      ST_SELECT: state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.commit;
    end
  end

  assign busy       = (state != ST_IDLE);
  assign cmd.clear  = (state == ST_CLEAR);
  assign cmd.load   = (state == ST_IDLE) && start;
  assign cmd.round1 = (state == ST_ROUND1);
  assign cmd.round2 = (state == ST_ROUND2);
  assign cmd.select = (state == ST_SELECT);
  assign cmd.commit = (state == ST_COMMIT);

endmodule

`default_nettype wire

// ===== src/bspa_dp.sv =====
// Datapath: placement table, high-water and retained-end memories, granule
// rounding, slot selection and result registers. Depends on bspa_pkg, bspa_ram.
`default_nettype none

module bspa_dp import bspa_pkg::*; #(
  parameter int NUM_BANKS    = NUM_BANKS_DEF,
  parameter int NUM_REGIONS  = NUM_REGIONS_DEF,
  parameter int SLOT_GRANULE = SLOT_GRANULE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire cfg_t        cfg,
  input  wire logic        func,
  input  wire logic [7:0]  region_id,
  input  wire logic [7:0]  bank,
  input  wire logic [15:0] original_addr,
  input  wire logic [14:0] region_bytes,
  output logic      [15:0] placed_addr,
  output logic      [14:0] slot_bytes,
  output logic      [21:0] linear_offset,
  output logic             reused,
  output logic signed [15:0] addr_delta
);

  localparam int BW        = $clog2(NUM_BANKS);
  localparam int RW        = $clog2(NUM_REGIONS);
  localparam int CLR_DEPTH = (NUM_REGIONS > NUM_BANKS) ? NUM_REGIONS : NUM_BANKS;
  localparam int CW        = $clog2(CLR_DEPTH);

  // floor(x / G) = (x * M) >> K, exact for x below 2^XW
  localparam int XW       = 17;
  localparam int GRAN_L   = $clog2(SLOT_GRANULE);
  localparam int GRAN_K   = XW + GRAN_L;
  localparam int GRAN_MW  = GRAN_K + 1;
  localparam int PW       = XW + GRAN_MW;
  localparam longint unsigned GRAN_M =
    ((64'd1 << GRAN_K) + SLOT_GRANULE - 1) / SLOT_GRANULE;
  localparam logic [PW-1:0] MULT   = PW'(GRAN_M);
  localparam logic [XW-1:0] GRAN   = XW'(SLOT_GRANULE);
  localparam logic [XW-1:0] GRAN_M1 = XW'(SLOT_GRANULE - 1);

  // input decode
  logic [7:0]    bank_cl;
  logic [RW-1:0] idx_in;

  always_comb begin
    if ({1'b0, bank} >= 9'(NUM_BANKS)) begin
      bank_cl = 8'(NUM_BANKS - 1);
    end else begin
      bank_cl = bank;
    end
  end

  generate
    if (NUM_REGIONS < 256) begin : g_idx_mod
      always_comb begin
        logic [11:0] r;
        r = {4'd0, region_id};
        for (int k = 3; k >= 0; k--) begin
          if (r >= (12'(NUM_REGIONS) << k)) begin
            r = r - (12'(NUM_REGIONS) << k);
          end
        end
        idx_in = r[RW-1:0];
      end
    end else begin : g_idx_pass
      assign idx_in = RW'(region_id);
    end
  endgenerate

  // item registers
  logic          func_q;
  logic [7:0]    bank_q;
  logic [RW-1:0] idx_q;
  logic [15:0]   orig_q;
  logic [14:0]   bytes_q;
  logic [PW-1:0] prod_b, prod_h;
  logic [XW-1:0] up_b, up_h;
  logic [14:0]   slot_new;
  logic [15:0]   addr_r;
  logic [14:0]   slot_r;
  logic          reused_r;

  // clearing counter
  logic [CW-1:0] clr_cnt;

  assign stat.clear_last = (clr_cnt == CW'(CLR_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear && !stat.clear_last) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // memories
  tab_entry_t    tab_rd, tab_wd;
  logic [15:0]   hw_rd, hw_wd, re_rd, re_wd;
  logic          tab_we, hw_we, re_we;
  logic [RW-1:0] tab_waddr, tab_raddr;
  logic [BW-1:0] bank_waddr, bank_raddr;
  logic [15:0]   slot_end;

  assign tab_raddr  = cmd.load ? idx_in : idx_q;
  assign bank_raddr = cmd.load ? bank_cl[BW-1:0] : bank_q[BW-1:0];

  assign slot_end = addr_r + {1'b0, slot_r};

  always_comb begin
    tab_we     = 1'b0;
    hw_we      = 1'b0;
    re_we      = 1'b0;
    tab_waddr  = idx_q;
    bank_waddr = bank_q[BW-1:0];
    tab_wd     = '{valid: 1'b1, bank: bank_q, addr: addr_r, slot: slot_r};
    hw_wd      = addr_r;
    re_wd      = slot_end;
    if (cmd.clear) begin
      tab_we     = ({1'b0, clr_cnt} < (CW + 1)'(NUM_REGIONS));
      hw_we      = ({1'b0, clr_cnt} < (CW + 1)'(NUM_BANKS));
      re_we      = hw_we;
      tab_waddr  = clr_cnt[RW-1:0];
      bank_waddr = clr_cnt[BW-1:0];
      tab_wd     = '0;
      hw_wd      = '0;
      re_wd      = '0;
    end else if (cmd.commit) begin
      if (!func_q) begin
        hw_we = 1'b1;
      end else begin
        hw_we  = (slot_end > hw_rd);
        hw_wd  = slot_end;
        tab_we = cfg.retain_enable;
        re_we  = cfg.retain_enable && (slot_end > re_rd);
      end
    end
  end

  bspa_ram #(.WIDTH($bits(tab_entry_t)), .DEPTH(NUM_REGIONS)) u_tab (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wd),
    .raddr (tab_raddr),
    .rdata (tab_rd)
  );

  bspa_ram #(.WIDTH(16), .DEPTH(NUM_BANKS)) u_hw (
    .clk   (clk),
    .we    (hw_we),
    .waddr (bank_waddr),
    .wdata (hw_wd),
    .raddr (bank_raddr),
    .rdata (hw_rd)
  );

  bspa_ram #(.WIDTH(16), .DEPTH(NUM_BANKS)) u_re (
    .clk   (clk),
    .we    (re_we),
    .waddr (bank_waddr),
    .wdata (re_wd),
    .raddr (bank_raddr),
    .rdata (re_rd)
  );

  // selection
  logic [17:0] slot_sum;
  logic [15:0] mark0, mark1, mark;
  logic [15:0] a1, a2, a3, a2_end;
  logic        reuse;
  logic        in_sect;

  assign slot_sum = 18'(up_b) + 18'(GRAN);
  assign in_sect  = (bank_q == cfg.section_bank);

  always_comb begin
    mark0 = in_sect ? cfg.section_base : 16'd0;
    mark1 = (orig_q > mark0) ? orig_q : mark0;
    mark  = (cfg.retain_enable && re_rd > mark1) ? re_rd : mark1;

    a1 = up_h[15:0];
    if (bank_q != 8'd0 && a1 < BANKED_BASE) begin
      a1 = BANKED_BASE;
    end
    a2 = (in_sect && a1 < cfg.section_base) ? cfg.section_base : a1;
    a2_end = a2 + {1'b0, slot_new};
    a3 = (bank_q == 8'd0 && a2 < HEADER_END && a2_end > HEADER_LO) ? HEADER_END : a2;

    reuse = cfg.retain_enable && tab_rd.valid && (tab_rd.bank == bank_q) &&
            (bytes_q <= tab_rd.slot);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= func;
      bank_q  <= bank_cl;
      idx_q   <= idx_in;
      orig_q  <= original_addr;
      bytes_q <= region_bytes;
      prod_b  <= (PW'({2'b00, region_bytes}) + PW'(GRAN_M1)) * MULT;
    end
    if (cmd.round1) begin
      up_b   <= prod_b[GRAN_K +: XW] * GRAN;
      prod_h <= (PW'(hw_rd) + PW'(GRAN_M1)) * MULT;
    end
    if (cmd.round2) begin
      up_h     <= prod_h[GRAN_K +: XW] * GRAN;
      slot_new <= (slot_sum > 18'(SLOT_MAX)) ? SLOT_MAX : slot_sum[14:0];
    end
    if (cmd.select) begin
      if (!func_q) begin
        addr_r   <= mark;
        slot_r   <= '0;
        reused_r <= 1'b0;
      end else if (reuse) begin
        addr_r   <= tab_rd.addr;
        slot_r   <= tab_rd.slot;
        reused_r <= 1'b1;
      end else begin
        addr_r   <= a3;
        slot_r   <= slot_new;
        reused_r <= 1'b0;
      end
    end
    if (cmd.commit) begin
      placed_addr <= addr_r;
      slot_bytes  <= slot_r;
      reused      <= reused_r;
      addr_delta  <= func_q ? signed'(addr_r - orig_q) : 16'sd0;
      if (bank_q == 8'd0) begin
        linear_offset <= 22'(addr_r);
      end else begin
        linear_offset <= {bank_q - 8'd1, 14'd0} + 22'(addr_r);
      end
    end
  end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for banked_slot_placement_allocator: directed and random
// region layouts, each result checked against an in-bench placement predictor.
// Depends on bspa_pkg and the allocator RTL.
module testbench;
  import bspa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  typedef struct {
    logic [15:0] addr;
    logic [14:0] slot;
    logic [21:0] offset;
    logic        reused;
    logic [15:0] delta;
  } placement_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              start;
  logic              busy;
  logic              func;
  logic [7:0]        region_id;
  logic [7:0]        bank;
  logic [15:0]       original_addr;
  logic [14:0]       region_bytes;
  logic              done;
  logic [15:0]       placed_addr;
  logic [14:0]       slot_bytes;
  logic [21:0]       linear_offset;
  logic              reused;
  logic signed [15:0] addr_delta;

  // predictor state
  logic [15:0] model_base;
  logic [7:0]  model_bank;
  logic        retain_on;
  logic        tab_valid [256];
  logic [7:0]  tab_bank  [256];
  logic [15:0] tab_addr  [256];
  logic [14:0] tab_slot  [256];
  logic [15:0] high_water [256];
  logic [15:0] ret_end    [256];

  placement_t placements_due[$];
  int         mismatch_count;
  int         idle_pct;
  int         quiet_cycles;

  banked_slot_placement_allocator i_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .region_id     (region_id),
    .bank          (bank),
    .original_addr (original_addr),
    .region_bytes  (region_bytes),
    .done          (done),
    .placed_addr   (placed_addr),
    .slot_bytes    (slot_bytes),
    .linear_offset (linear_offset),
    .reused        (reused),
    .addr_delta    (addr_delta)
  );

  always #5 clk = ~clk;

  function automatic int unsigned granule_round(int unsigned v);
    return ((v + SLOT_GRANULE_DEF - 1) / SLOT_GRANULE_DEF) * SLOT_GRANULE_DEF;
  endfunction

  function automatic placement_t predict_placement(logic f, logic [7:0] id, logic [7:0] bk,
                                                   logic [15:0] orig, logic [14:0] nbytes);
    placement_t  r;
    logic [15:0] a;
    logic [15:0] slot_end;
    int unsigned slot;
    r.reused = 1'b0;
    r.delta  = 16'h0;
    slot     = 0;
    if (!f) begin
      a = (bk == model_bank) ? model_base : 16'h0;
      if (orig > a) a = orig;
      if (retain_on && ret_end[bk] > a) a = ret_end[bk];
      high_water[bk] = a;
    end else if (retain_on && tab_valid[id] && tab_bank[id] == bk && nbytes <= tab_slot[id]) begin
      a        = tab_addr[id];
      slot     = tab_slot[id];
      r.reused = 1'b1;
    end else begin
      slot = granule_round(nbytes) + SLOT_GRANULE_DEF;
      if (slot > SLOT_MAX) slot = SLOT_MAX;
      a = 16'(granule_round(high_water[bk]));
      if (bk != 8'd0 && a < BANKED_BASE) a = BANKED_BASE;
      if (bk == model_bank && a < model_base) a = model_base;
      if (bk == 8'd0 && a < HEADER_END && 16'(a + slot) > HEADER_LO) a = HEADER_END;
    end
    if (f) begin
      slot_end = 16'(a + slot);
      if (slot_end > high_water[bk]) high_water[bk] = slot_end;
      if (retain_on) begin
        tab_valid[id] = 1'b1;
        tab_bank[id]  = bk;
        tab_addr[id]  = a;
        tab_slot[id]  = 15'(slot);
        if (slot_end > ret_end[bk]) ret_end[bk] = slot_end;
      end
      r.delta = a - orig;
    end
    r.addr   = a;
    r.slot   = 15'(slot);
    r.offset = (bk == 8'd0) ? 22'(a) : 22'(bk * 32'h4000 + a - 32'h4000);
    return r;
  endfunction

  function automatic logic [14:0] pick_size();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return 15'($urandom_range(300));
    if (roll < 90) return 15'($urandom_range(4096));
    if (roll < 98) return 15'($urandom_range(16384));
    return 15'($urandom_range(32767, 16384));
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    placement_t want;
    if (!rst && done === 1'b1) begin
      if (placements_due.size() == 0) begin
        report_mismatch($sformatf("result with none pending, placed_addr=%h", placed_addr));
      end else begin
        want = placements_due.pop_front();
        if (placed_addr !== want.addr)
          report_mismatch($sformatf("placed_addr %h, want %h", placed_addr, want.addr));
        if (slot_bytes !== want.slot)
          report_mismatch($sformatf("slot_bytes %h, want %h", slot_bytes, want.slot));
        if (linear_offset !== want.offset)
          report_mismatch($sformatf("linear_offset %h, want %h", linear_offset, want.offset));
        if (reused !== want.reused)
          report_mismatch($sformatf("reused %b, want %b", reused, want.reused));
        if (addr_delta !== want.delta)
          report_mismatch($sformatf("addr_delta %h, want %h", addr_delta, want.delta));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || done === 1'b1 || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_item(input logic f, input logic [7:0] id, input logic [7:0] bk,
                           input logic [15:0] orig, input logic [14:0] nbytes);
    int gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 8);
      @(negedge clk) start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    func          = f;
    region_id     = id;
    bank          = bk;
    original_addr = orig;
    region_bytes  = nbytes;
    start         = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    placements_due.push_back(predict_placement(f, id, bk, orig, nbytes));
  endtask

  task automatic settle();
    @(negedge clk) start = 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic check_reg(reg_idx_t idx);
    logic [31:0] want;
    case (idx)
      REG_SECTION_BASE:  want = 32'(model_base);
      REG_SECTION_BANK:  want = 32'(model_bank);
      default:           want = 32'(retain_on);
    endcase
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report_mismatch($sformatf("register %s reads %h, want %h", idx.name(), prdata, want));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk) penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SECTION_BASE:  model_base = value[15:0];
      REG_SECTION_BANK:  model_bank = value[7:0];
      default:           retain_on  = value[0];
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    check_reg(idx);
  endtask

  task automatic apply_settings(logic [15:0] base, logic [7:0] sbank, logic keep);
    settle();
    write_reg(REG_SECTION_BASE, 32'(base));
    write_reg(REG_SECTION_BANK, 32'(sbank));
    write_reg(REG_RETAIN_ENABLE, 32'(keep));
  endtask

  task automatic test_register_reset();
    settle();
    check_reg(REG_SECTION_BASE);
    check_reg(REG_SECTION_BANK);
    check_reg(REG_RETAIN_ENABLE);
  endtask

  // reset settings: section at 0x150 in bank 0, retention on
  task automatic test_default_layout();
    idle_pct = 0;
    send_item(1'b0, 8'd0,   8'd0,   16'h0000, 15'd0);
    send_item(1'b1, 8'd0,   8'd0,   16'h0150, 15'd0);
    send_item(1'b1, 8'd255, 8'd0,   16'hFFFF, 15'd16384);
    send_item(1'b1, 8'd0,   8'd0,   16'h0150, 15'd8);
    send_item(1'b1, 8'd0,   8'd0,   16'h0000, 15'd17);
    send_item(1'b0, 8'd1,   8'd255, 16'hFFFF, 15'h7FFF);
    send_item(1'b1, 8'd1,   8'd255, 16'h0000, 15'h7FFF);
    send_item(1'b1, 8'd2,   8'd255, 16'h1234, 15'h7FF1);
    send_item(1'b1, 8'd1,   8'd7,   16'h4000, 15'd100);
    send_item(1'b0, 8'd0,   8'd7,   16'h0000, 15'd0);
    send_item(1'b0, 8'd0,   8'd7,   16'hFFF8, 15'd0);
    send_item(1'b1, 8'd3,   8'd7,   16'h8000, 15'd1);
    send_item(1'b1, 8'd0,   8'd1,   16'h4000, 15'd15);
  endtask

  // header window in bank 0, section raise in bank 0 and elsewhere, retention off and then on
  task automatic test_header_window();
    apply_settings(16'h0000, 8'd9, 1'b0);
    send_item(1'b0, 8'd0,  8'd0, 16'h00F0, 15'd0);
    send_item(1'b1, 8'd10, 8'd0, 16'h00F0, 15'd16);
    send_item(1'b0, 8'd0,  8'd0, 16'h0000, 15'd0);
    send_item(1'b1, 8'd11, 8'd0, 16'h0000, 15'd0);
    send_item(1'b1, 8'd12, 8'd0, 16'h0010, 15'd240);
    send_item(1'b0, 8'd0,  8'd0, 16'h0140, 15'd0);
    send_item(1'b1, 8'd0,  8'd0, 16'h0140, 15'd0);
    send_item(1'b0, 8'd0,  8'd9, 16'h0000, 15'd0);
    send_item(1'b1, 8'd13, 8'd9, 16'h0000, 15'd32);
    apply_settings(16'h0120, 8'd0, 1'b0);
    send_item(1'b0, 8'd0,  8'd0, 16'h0000, 15'd0);
    send_item(1'b1, 8'd14, 8'd0, 16'h0100, 15'd0);
    apply_settings(16'h8000, 8'd9, 1'b1);
    send_item(1'b0, 8'd0,  8'd9, 16'h0000, 15'd0);
    send_item(1'b1, 8'd13, 8'd9, 16'h0000, 15'd64);
  endtask

  // bank-start then a run of places per bank, from small bank and id pools, mixed with fully random items
  task automatic test_random_layout(int pct, int n_items);
    logic [7:0] banks[4];
    logic [7:0] ids[8];
    logic [7:0] bk;
    int         sent;
    int         places;
    idle_pct = pct;
    banks[0] = model_bank;
    banks[1] = 8'd0;
    banks[2] = 8'($urandom_range(255));
    banks[3] = 8'($urandom_range(255, 1));
    foreach (ids[k]) ids[k] = 8'($urandom_range(255));
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                  16'($urandom_range(65535)), 15'($urandom_range(32767)));
        sent++;
      end else begin
        bk = banks[$urandom_range(3)];
        send_item(1'b0, 8'($urandom_range(255)), bk,
                  ($urandom_range(1) != 0) ? 16'($urandom_range(16'h1FF))
                                           : 16'($urandom_range(65535)),
                  15'($urandom_range(32767)));
        sent++;
        places = $urandom_range(6, 1);
        repeat (places) begin
          send_item(1'b1, ids[$urandom_range(7)], bk, 16'($urandom_range(65535)), pick_size());
          sent++;
        end
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    start          = 1'b0;
    func           = 1'b0;
    region_id      = '0;
    bank           = '0;
    original_addr  = '0;
    region_bytes   = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    idle_pct       = 0;
    model_base     = SECTION_BASE_RST;
    model_bank     = SECTION_BANK_RST;
    retain_on      = RETAIN_ENABLE_RST;
    for (int k = 0; k < 256; k++) begin
      tab_valid[k]  = 1'b0;
      tab_bank[k]   = '0;
      tab_addr[k]   = '0;
      tab_slot[k]   = '0;
      high_water[k] = '0;
      ret_end[k]    = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    test_register_reset();
    test_default_layout();
    test_header_window();
    apply_settings(16'($urandom_range(16'h3FFF)), 8'd0, 1'b1);
    test_random_layout(0, 150);
    apply_settings(16'hFFFF, 8'd255, 1'b1);
    test_random_layout(72, 150);
    apply_settings(16'h0000, 8'($urandom_range(254, 1)), 1'b0);
    test_random_layout(24, 150);
    apply_settings(16'($urandom_range(65535)), 8'($urandom_range(255)), 1'b1);
    test_random_layout(0, 150);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && placements_due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
